>>> rtl/cfr_pkg.sv
// ---------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the CRC frame receiver modules.
// ---------------------------------------------------------------------------
package cfr_pkg;

   localparam logic [7:0]  HDR_BYTE   = 8'hAA;
   localparam logic [7:0]  TAIL_BYTE  = 8'h55;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] POLY_MODBUS = 16'hA001;
   localparam logic [15:0] POLY_CCITT  = 16'h1021;

   localparam logic MODE_MODBUS = 1'b0;
   localparam logic MODE_CCITT  = 1'b1;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_CRC  = 2'd1;
   localparam logic [1:0] ERR_TAIL = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_ID,
      PH_CMD,
      PH_LEN,
      PH_DATA,
      PH_CRCH,
      PH_CRCL,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [63:0] unit_id;
      logic [7:0]  command;
      logic [7:0]  payload_length;
      logic [1:0]  error;
   } result_type;

endpackage

>>> rtl/cfr_crc16.sv
// ---------------------------------------------------------------------------
// cfr_crc16
// One-byte CRC-16 update, MODBUS (reflected) or CCITT-FALSE (MSB first).
// ---------------------------------------------------------------------------
module cfr_crc16 (
   input  logic [15:0] acc,
   input  logic [7:0]  data,
   input  logic        mode,
   output logic [15:0] acc_next
);

   always_comb begin
      logic [15:0] c;
      if (mode == cfr_pkg::MODE_CCITT) begin
         c = acc ^ {data, 8'h00};
         for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
               c = {c[14:0], 1'b0} ^ cfr_pkg::POLY_CCITT;
            end else begin
               c = {c[14:0], 1'b0};
            end
         end
      end else begin
         c = acc ^ {8'h00, data};
         for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
               c = {1'b0, c[15:1]} ^ cfr_pkg::POLY_MODBUS;
            end else begin
               c = {1'b0, c[15:1]};
            end
         end
      end
      acc_next = c;
   end

endmodule

>>> rtl/cfr_parser.sv
// ---------------------------------------------------------------------------
// cfr_parser
// Frame phase machine: header hunt, ID/command/length capture, payload CRC,
// CRC compare and tail check. Result is combinational from the current item.
// ---------------------------------------------------------------------------
module cfr_parser #(
   parameter int ID_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic                   flush,
   input  logic                   crc_mode,
   output logic                   res_valid,
   output cfr_pkg::result_type    res
);

   cfr_pkg::phase_type phase_ff, phase_in;
   logic [63:0] id_ff, id_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crch_ff, crch_in;
   logic        bad_ff, bad_in;
   logic [7:0]  count_inc;
   logic [15:0] crc_upd;

   assign count_inc = count_ff + 8'd1;

   cfr_crc16 u_crc (
      .acc      (crc_ff),
      .data     (rx_byte),
      .mode     (crc_mode),
      .acc_next (crc_upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfr_pkg::PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      cmd_ff   <= cmd_in;
      len_ff   <= len_in;
      count_ff <= count_in;
      crc_ff   <= crc_in;
      crch_ff  <= crch_in;
      bad_ff   <= bad_in;
   end

   always_comb begin
      phase_in = phase_ff;
      id_in    = id_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      crch_in  = crch_ff;
      bad_in   = bad_ff;

      res_valid          = 1'b0;
      res.kind           = cfr_pkg::KIND_PAYLOAD;
      res.payload_byte   = 8'h00;
      res.unit_id        = id_ff;
      res.command        = cmd_ff;
      res.payload_length = len_ff;
      res.error          = cfr_pkg::ERR_NONE;

      if (step) begin
         if (flush) begin
            phase_in = cfr_pkg::PH_HUNT;
         end else begin
            unique case (phase_ff)
               cfr_pkg::PH_HUNT: begin
                  if (rx_byte == cfr_pkg::HDR_BYTE) begin
                     id_in    = 64'd0;
                     cmd_in   = 8'd0;
                     len_in   = 8'd0;
                     count_in = 8'd0;
                     crc_in   = cfr_pkg::CRC_INIT;
                     crch_in  = 8'd0;
                     bad_in   = 1'b0;
                     phase_in = cfr_pkg::PH_ID;
                  end
               end
               cfr_pkg::PH_ID: begin
                  for (int k = 0; k < 8; k++) begin
                     if (count_ff[2:0] == 3'(k)) begin
                        id_in[8*k +: 8] = id_ff[8*k +: 8] | rx_byte;
                     end
                  end
                  count_in = count_inc;
                  if (count_inc >= 8'(ID_BYTES)) begin
                     phase_in = cfr_pkg::PH_CMD;
                  end
               end
               cfr_pkg::PH_CMD: begin
                  cmd_in   = rx_byte;
                  phase_in = cfr_pkg::PH_LEN;
               end
               cfr_pkg::PH_LEN: begin
                  len_in   = rx_byte;
                  count_in = 8'd0;
                  phase_in = (rx_byte == 8'd0) ? cfr_pkg::PH_CRCH : cfr_pkg::PH_DATA;
               end
               cfr_pkg::PH_DATA: begin
                  crc_in   = crc_upd;
                  count_in = count_inc;
                  if (count_inc >= len_ff) begin
                     phase_in = cfr_pkg::PH_CRCH;
                  end
                  res_valid        = 1'b1;
                  res.payload_byte = rx_byte;
               end
               cfr_pkg::PH_CRCH: begin
                  crch_in  = rx_byte;
                  phase_in = cfr_pkg::PH_CRCL;
               end
               cfr_pkg::PH_CRCL: begin
                  bad_in   = ({crch_ff, rx_byte} != crc_ff);
                  phase_in = cfr_pkg::PH_TAIL;
               end
               cfr_pkg::PH_TAIL: begin
                  res_valid = 1'b1;
                  if (bad_ff) begin
                     res.error = cfr_pkg::ERR_CRC;
                  end else if (rx_byte != cfr_pkg::TAIL_BYTE) begin
                     res.error = cfr_pkg::ERR_TAIL;
                  end
                  res.kind = (res.error == cfr_pkg::ERR_NONE) ? cfr_pkg::KIND_ACCEPT
                                                              : cfr_pkg::KIND_REJECT;
                  phase_in = cfr_pkg::PH_HUNT;
               end
               default: begin
                  phase_in = cfr_pkg::PH_HUNT;
               end
            endcase
         end
      end
   end

endmodule

>>> rtl/crc_frame_receiver.sv
// ---------------------------------------------------------------------------
// crc_frame_receiver
// Byte-serial receiver for length-prefixed frames with CRC-16 over payload.
//
//   channel  dir  handshake            contents
//   req_     in   req_valid/req_ready  rx_byte, flush
//   rsp_     out  rsp_valid/rsp_ready  kind, payload_byte, unit_id, ...
//   csr_     in   csr_valid/csr_ready  crc_mode (always ready)
//
// One item per cycle unless rsp_ready stalls: input register, combinational
// phase/CRC step, result register. An item that yields a result passes both registers.
// While a result waits on rsp_ready the input register takes at most one
// more item, then req_ready drops.
// Reset clears the phase to header hunt and the CRC mode to MODBUS.
// ---------------------------------------------------------------------------
module crc_frame_receiver #(
   parameter int ID_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_flush,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [63:0] rsp_unit_id,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_payload_length,
   output logic [1:0]  rsp_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_crc_mode
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_flush_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   cfr_pkg::result_type rsp_ff;
   logic                mode_ff;
   logic                advance;
   logic                step;
   logic                res_valid;
   cfr_pkg::result_type res;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? (step && res_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= cfr_pkg::MODE_MODBUS;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_crc_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_rx_byte;
         in_flush_ff <= req_flush;
      end
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   cfr_parser #(
      .ID_BYTES (ID_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .flush     (in_flush_ff),
      .crc_mode  (mode_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_unit_id        = rsp_ff.unit_id;
   assign rsp_command        = rsp_ff.command;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_error          = rsp_ff.error;

   a_payload_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind == cfr_pkg::KIND_PAYLOAD |-> rsp_error == cfr_pkg::ERR_NONE)
      else $error("payload item carries an error code");

   a_verdict_matches_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind != cfr_pkg::KIND_PAYLOAD |->
         ((rsp_kind == cfr_pkg::KIND_ACCEPT) == (rsp_error == cfr_pkg::ERR_NONE)))
      else $error("frame verdict disagrees with error code");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind == cfr_pkg::KIND_PAYLOAD || rsp_kind == cfr_pkg::KIND_ACCEPT ||
                        rsp_kind == cfr_pkg::KIND_REJECT))
      else $error("illegal result kind");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input item lost while output stalled");

endmodule
